// ===== rtl/assert_macros.svh =====
// assertion helpers for the retry sequencer checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property that must hold at every clock edge outside reset
`define DERS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define DERS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ders_pkg.sv =====
`timescale 1ns / 1ps

package ders_pkg;

  localparam logic [2:0] ACT_OK      = 3'd0;
  localparam logic [2:0] ACT_ERR     = 3'd1;
  localparam logic [2:0] ACT_RESTART = 3'd2;
  localparam logic [2:0] ACT_RECAL   = 3'd3;
  localparam logic [2:0] ACT_SEEK    = 3'd4;
  localparam logic [2:0] ACT_OFFSET  = 3'd5;

  localparam logic [1:0] STG_IDLE   = 2'd0;
  localparam logic [1:0] STG_SEEK   = 2'd1;
  localparam logic [1:0] STG_OFFSET = 2'd2;
  localparam logic [1:0] STG_DONE   = 2'd3;

  localparam logic [1:0] REG_RETRY_LIMIT  = 2'd0;
  localparam logic [1:0] REG_OFFSET_START = 2'd1;
  localparam logic [1:0] REG_RECAL_PHASE  = 2'd2;

  localparam logic [4:0] RETRY_LIMIT_RST  = 5'd28;
  localparam logic [4:0] OFFSET_START_RST = 5'd16;
  localparam logic [2:0] RECAL_PHASE_RST  = 3'd4;

  localparam logic [4:0] COUNT_MAX = 5'd31;

  typedef struct packed {
    logic [4:0] retry_limit;
    logic [4:0] offset_start;
    logic [2:0] recal_phase;
  } cfg_t;

  typedef struct packed {
    logic [4:0] error_count;
    logic [1:0] recal_stage;
    logic       failed_flag;
  } seq_state_t;

  typedef struct packed {
    logic [2:0] action;
    logic [9:0] seek_cylinder;
    logic [2:0] offset_code;
    logic       clear_subsystem;
  } result_t;

  // head offset by retry count: +/-400, +/-800, +/-1200 pairs, none at the top
  function automatic logic [2:0] offset_lookup(input logic [3:0] idx);
    logic [2:0] code;
    case (idx)
      4'd0, 4'd2:  code = 3'd1;
      4'd1, 4'd3:  code = 3'd2;
      4'd4, 4'd6:  code = 3'd3;
      4'd5, 4'd7:  code = 3'd4;
      4'd8, 4'd10: code = 3'd5;
      4'd9, 4'd11: code = 3'd6;
      default:     code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/ders_cfg_regs.sv =====
`timescale 1ns / 1ps

module ders_cfg_regs import ders_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_limit  <= RETRY_LIMIT_RST;
      cfg_q.offset_start <= OFFSET_START_RST;
      cfg_q.recal_phase  <= RECAL_PHASE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RETRY_LIMIT:  cfg_q.retry_limit  <= pwdata[4:0];
        REG_OFFSET_START: cfg_q.offset_start <= pwdata[4:0];
        REG_RECAL_PHASE:  cfg_q.recal_phase  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RETRY_LIMIT:  prdata = {27'd0, cfg_q.retry_limit};
      REG_OFFSET_START: prdata = {27'd0, cfg_q.offset_start};
      REG_RECAL_PHASE:  prdata = {29'd0, cfg_q.recal_phase};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/ders_decide.sv =====
`timescale 1ns / 1ps

module ders_decide import ders_pkg::*; (
  input  cfg_t       cfg_i,
  input  seq_state_t st_i,
  input  logic       command_error_i,
  input  logic       write_locked_i,
  input  logic       hard_fault_i,
  input  logic       bad_sector_i,
  input  logic       missed_sync_i,
  input  logic       position_fault_i,
  input  logic       is_read_i,
  input  logic [9:0] target_cylinder_i,
  output seq_state_t st_o,
  output result_t    res_o
);

  always_comb begin
    seq_state_t st;
    result_t    res;
    logic [5:0] cnt_inc;
    logic       active;
    logic       advance;
    logic       issued;
    logic       recal;

    st        = st_i;
    res       = '0;
    res.action = ACT_OK;
    active    = 1'b1;
    advance   = 1'b1;
    issued    = 1'b0;
    cnt_inc   = {1'b0, st_i.error_count} + 6'd1;
    recal     = 1'b0;

    if (command_error_i) begin
      if (write_locked_i) begin
        // write lock fails the transfer but leaves any recovery running
        st.failed_flag = 1'b1;
      end else begin
        st.error_count = cnt_inc[5] ? COUNT_MAX : cnt_inc[4:0];
        if ((cnt_inc > {1'b0, cfg_i.retry_limit}) || hard_fault_i || bad_sector_i) begin
          st.failed_flag = 1'b1;
          st.recal_stage = STG_IDLE;
        end else begin
          active = 1'b0;
        end
      end
      if (missed_sync_i) begin
        res.clear_subsystem = 1'b1;
      end else begin
        recal = position_fault_i || (st.error_count[2:0] == cfg_i.recal_phase);
        if (recal && !active) begin
          st.recal_stage = STG_SEEK;
          res.action     = ACT_RECAL;
          advance        = 1'b0;
          active         = 1'b1;
        end
      end
    end

    if (advance) begin
      case (st.recal_stage)
        STG_SEEK: begin
          st.recal_stage    = STG_OFFSET;
          res.action        = ACT_SEEK;
          res.seek_cylinder = target_cylinder_i;
          issued            = 1'b1;
        end
        STG_OFFSET: begin
          if ((st.error_count < cfg_i.offset_start) || !is_read_i) begin
            st.recal_stage = STG_IDLE;
            active         = 1'b0;
          end else begin
            res.offset_code = offset_lookup(st.error_count[3:0]);
            st.recal_stage  = STG_DONE;
            res.action      = ACT_OFFSET;
            issued          = 1'b1;
          end
        end
        STG_DONE: begin
          st.recal_stage = STG_IDLE;
          active         = 1'b0;
        end
        default: ;
      endcase
      if (!issued) begin
        if (active) begin
          res.action     = st.failed_flag ? ACT_ERR : ACT_OK;
          st.error_count = '0;
          st.failed_flag = 1'b0;
        end else begin
          res.action = ACT_RESTART;
        end
      end
    end

    st_o  = st;
    res_o = res;
  end

endmodule

// ===== rtl/disk_error_retry_sequencer_core.sv =====
`timescale 1ns / 1ps

// Disk error retry sequencer: takes one completion event per interrupt of the
// active transfer and returns the next recovery action (done, fail, restart,
// recalibrate, seek or head offset) with its seek cylinder, offset code and a
// subsystem clear request. Decision logic reads the retry state registers and
// the event and loads the state and result registers at the same edge, so a
// new event is taken every cycle unless in_stall_o is high; the result
// appears in the cycle after its transfer. in_stall_o is raised only while
// the consumer stalls a held result. The user must write the configuration
// registers (retry_limit at 0x0, offset_start at 0x4, recal_phase at 0x8)
// over the APB port only while the block is idle, which it does not enforce.
module disk_error_retry_sequencer_core import ders_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_error_i,
  input  logic        write_locked_i,
  input  logic        hard_fault_i,
  input  logic        bad_sector_i,
  input  logic        missed_sync_i,
  input  logic        position_fault_i,
  input  logic        is_read_i,
  input  logic [9:0]  target_cylinder_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [9:0]  seek_cylinder_o,
  output logic [2:0]  offset_code_o,
  output logic        clear_subsystem_o
);

  cfg_t       cfg;
  seq_state_t st_q, st_d;
  result_t    res_d, res_q;
  logic       out_valid_q;
  logic       in_xfer;

  ders_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ders_decide u_decide (
    .cfg_i             (cfg),
    .st_i              (st_q),
    .command_error_i   (command_error_i),
    .write_locked_i    (write_locked_i),
    .hard_fault_i      (hard_fault_i),
    .bad_sector_i      (bad_sector_i),
    .missed_sync_i     (missed_sync_i),
    .position_fault_i  (position_fault_i),
    .is_read_i         (is_read_i),
    .target_cylinder_i (target_cylinder_i),
    .st_o              (st_d),
    .res_o             (res_d)
  );

  // result register frees up in the same cycle its transfer completes
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        st_q <= st_d;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign action_o          = res_q.action;
  assign seek_cylinder_o   = res_q.seek_cylinder;
  assign offset_code_o     = res_q.offset_code;
  assign clear_subsystem_o = res_q.clear_subsystem;

endmodule

// ===== rtl/ders_checker.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ders_checker import ders_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] action_o,
  input logic [9:0] seek_cylinder_o,
  input logic [2:0] offset_code_o
);

  `DERS_ASSERT_IMPLY(a_seek_only_on_seek, clk_i, rst_ni, out_valid_o && (seek_cylinder_o != 10'd0), action_o == ACT_SEEK, "seek cylinder set outside a seek")
  `DERS_ASSERT_IMPLY(a_offset_only_on_offset, clk_i, rst_ni, out_valid_o && (offset_code_o != 3'd0), action_o == ACT_OFFSET, "offset code set outside an offset step")
  `DERS_ASSERT_IMPLY(a_action_legal, clk_i, rst_ni, out_valid_o, action_o <= ACT_OFFSET, "action code out of range")
  `DERS_ASSERT_IMPLY(a_valid_held, clk_i, rst_ni, $past(out_valid_o && out_stall_i), out_valid_o, "result dropped while stalled")
  `DERS_ASSERT(a_action_held, clk_i, rst_ni, !$past(out_valid_o && out_stall_i) || $stable(action_o), "action changed while stalled")

endmodule

bind disk_error_retry_sequencer_core ders_checker u_ders_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .action_o        (action_o),
  .seek_cylinder_o (seek_cylinder_o),
  .offset_code_o   (offset_code_o)
);
